// ----- rtl/hds_pkg.sv -----
// Shared types and constants for the 2D heat diffusion step block.
package hds_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_COLS_DEF   = 32;
    localparam int VALUE_BITS_DEF = 32;

    // Fixed field and register widths
    localparam int ROW_BITS      = 12;
    localparam int COL_OUT_BITS  = 5;
    localparam int GAIN_BITS     = 16;
    localparam int ROWS_CFG_BITS = 13;
    localparam int COLS_CFG_BITS = 6;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 16;
    localparam int MAX_ROWS      = 4096;

    // Fractional bits of the gains, and the rounding half step
    localparam int FRAC_BITS = 16;
    localparam int ROUND_HALF = 32768;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_GRID_ROWS = 2'd0,
        CFG_GRID_COLS = 2'd1,
        CFG_ROW_GAIN  = 2'd2,
        CFG_COL_GAIN  = 2'd3
    } t_cfg_idx;

    // Position tag carried along the update pipeline with each result
    typedef struct packed {
        logic [ROW_BITS-1:0]     row;
        logic [COL_OUT_BITS-1:0] col;
        logic                    last;
    } t_meta;

endpackage

// ----- rtl/heat_diffusion_step_2d_cartesian.sv -----
// Top level: raster control, row delay chains and the update pipeline.
//
// One explicit diffusion step over a grid streamed in raster order. The block
// accepts one node per cycle while tready is high; an input in row i (i >= 1)
// yields the updated node of row i-1, same column, from the update pipeline.
// After the last node of the grid the block holds tready low while it shifts
// the two row delay chains and emits the whole final row, the last result
// with tlast set. Two chains of MAX_COLS cells hold the previous rows; their
// active length follows grid_cols, so no memory or clearing pass is involved.
// Writing grid_rows or grid_cols restarts the pass at row 0, column 0.
module heat_diffusion_step_2d_cartesian
    import hds_pkg::*;
#(
    parameter int MAX_COLS   = MAX_COLS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    localparam int SDW       = ((VALUE_BITS + 7) / 8) * 8,
    localparam int MDW       = ((VALUE_BITS + ROW_BITS + COL_OUT_BITS + 7) / 8) * 8
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration write port
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    // input stream
    input  logic                     i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    input  logic [SDW-1:0]           i_s_axis_tdata,   // node_value
    // output stream
    output logic                     o_m_axis_tvalid,
    input  logic                     i_m_axis_tready,
    output logic [MDW-1:0]           o_m_axis_tdata,   // new_value, out_row, out_col
    output logic                     o_m_axis_tlast    // frame_last
);

    localparam int CW = $clog2(MAX_COLS);

    logic [ROWS_CFG_BITS-1:0] r_rows_cfg;
    logic [COLS_CFG_BITS-1:0] r_cols_cfg;
    logic [GAIN_BITS-1:0]     r_row_gain;
    logic [GAIN_BITS-1:0]     r_col_gain;

    logic [ROW_BITS-1:0] r_row;
    logic [CW-1:0]       r_col;
    logic                r_flush;
    logic [CW-1:0]       r_fcol;
    logic signed [VALUE_BITS-1:0] r_prev;

    logic [ROW_BITS-1:0] w_rows_m1;
    logic [CW-1:0]       w_cols_m1;
    logic                w_adv, w_accept, w_shift, w_emit, w_end_grid;
    logic [CW-1:0]       w_col_sel;
    logic signed [VALUE_BITS-1:0] w_x;
    logic signed [VALUE_BITS-1:0] w_t1_0, w_t1_1, w_t2_0;
    logic signed [VALUE_BITS-1:0] w_up, w_dn, w_lf, w_rt;
    t_meta               w_meta;
    logic                w_out_valid;
    logic [VALUE_BITS-1:0] w_out_value;
    t_meta               w_out_meta;

    // Clamped grid size, as last index
    always_comb begin
        priority if (r_rows_cfg < ROWS_CFG_BITS'(2)) begin
            w_rows_m1 = ROW_BITS'(1);
        end else if (r_rows_cfg > ROWS_CFG_BITS'(MAX_ROWS)) begin
            w_rows_m1 = ROW_BITS'(MAX_ROWS - 1);
        end else begin
            w_rows_m1 = ROW_BITS'(r_rows_cfg - ROWS_CFG_BITS'(1));
        end
        priority if (r_cols_cfg < COLS_CFG_BITS'(2)) begin
            w_cols_m1 = CW'(1);
        end else if (32'(r_cols_cfg) > 32'(MAX_COLS)) begin
            w_cols_m1 = CW'(MAX_COLS - 1);
        end else begin
            w_cols_m1 = CW'(r_cols_cfg - COLS_CFG_BITS'(1));
        end
    end

    // Handshake and pipeline advance
    assign w_adv           = !w_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = w_adv && !r_flush;
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_shift         = w_accept || (w_adv && r_flush);
    assign w_emit          = (w_accept && (r_row != '0)) || (w_adv && r_flush);
    assign w_end_grid      = (r_row == w_rows_m1) && (r_col == w_cols_m1);
    assign w_x             = signed'(i_s_axis_tdata[VALUE_BITS-1:0]);

    // Row delay chains: current/previous row, and the row before that
    hds_line #(
        .MAX_COLS  (MAX_COLS),
        .VALUE_BITS(VALUE_BITS)
    ) u_line1 (
        .i_clk     (i_clk),
        .i_shift   (w_shift),
        .i_last_idx(w_cols_m1),
        .i_din     (w_x),
        .o_tap0    (w_t1_0),
        .o_tap1    (w_t1_1)
    );

    hds_line #(
        .MAX_COLS  (MAX_COLS),
        .VALUE_BITS(VALUE_BITS)
    ) u_line2 (
        .i_clk     (i_clk),
        .i_shift   (w_shift),
        .i_last_idx(w_cols_m1),
        .i_din     (w_t1_0),
        .o_tap0    (w_t2_0),
        .o_tap1    ()
    );

    // Left neighbor is the chain head one item earlier
    always_ff @(posedge i_clk) begin
        if (w_shift) begin
            r_prev <= w_t1_0;
        end
    end

    // Stencil operands with Neumann mirroring on the edges
    always_comb begin
        w_col_sel = r_flush ? r_fcol : r_col;
        w_dn      = r_flush ? w_t2_0 : w_x;
        if (!r_flush && (r_row == ROW_BITS'(1))) begin
            w_up = w_x;
        end else begin
            w_up = w_t2_0;
        end
        w_lf = (w_col_sel == '0) ? w_t1_1 : r_prev;
        w_rt = (w_col_sel == w_cols_m1) ? r_prev : w_t1_1;
        w_meta.row  = r_flush ? r_row : (r_row - ROW_BITS'(1));
        w_meta.col  = COL_OUT_BITS'(w_col_sel);
        w_meta.last = r_flush && (r_fcol == w_cols_m1);
    end

    // Raster position, final-row flush and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_cfg <= ROWS_CFG_BITS'(2);
            r_cols_cfg <= COLS_CFG_BITS'(32);
            r_row_gain <= '0;
            r_col_gain <= '0;
            r_row      <= '0;
            r_col      <= '0;
            r_flush    <= 1'b0;
            r_fcol     <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_GRID_ROWS: begin
                    r_rows_cfg <= i_cfg_data[ROWS_CFG_BITS-1:0];
                    r_row      <= '0;
                    r_col      <= '0;
                    r_flush    <= 1'b0;
                end
                CFG_GRID_COLS: begin
                    r_cols_cfg <= i_cfg_data[COLS_CFG_BITS-1:0];
                    r_row      <= '0;
                    r_col      <= '0;
                    r_flush    <= 1'b0;
                end
                CFG_ROW_GAIN: r_row_gain <= i_cfg_data[GAIN_BITS-1:0];
                CFG_COL_GAIN: r_col_gain <= i_cfg_data[GAIN_BITS-1:0];
                default: ;
            endcase
        end else if (r_flush) begin
            if (w_adv) begin
                if (r_fcol == w_cols_m1) begin
                    r_flush <= 1'b0;
                    r_row   <= '0;
                    r_col   <= '0;
                end else begin
                    r_fcol <= r_fcol + CW'(1);
                end
            end
        end else if (w_accept) begin
            if (w_end_grid) begin
                r_flush <= 1'b1;
                r_fcol  <= '0;
            end else if (r_col == w_cols_m1) begin
                r_row <= r_row + ROW_BITS'(1);
                r_col <= '0;
            end else begin
                r_col <= r_col + CW'(1);
            end
        end
    end

    hds_update #(
        .VALUE_BITS(VALUE_BITS)
    ) u_update (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (w_adv),
        .i_valid   (w_emit),
        .i_center  (w_t1_0),
        .i_up      (w_up),
        .i_down    (w_dn),
        .i_left    (w_lf),
        .i_right   (w_rt),
        .i_meta    (w_meta),
        .i_row_gain(r_row_gain),
        .i_col_gain(r_col_gain),
        .o_valid   (w_out_valid),
        .o_value   (w_out_value),
        .o_meta    (w_out_meta)
    );

    // Output packing
    assign o_m_axis_tvalid = w_out_valid;
    assign o_m_axis_tdata  = MDW'({w_out_meta.col, w_out_meta.row, w_out_value});
    assign o_m_axis_tlast  = w_out_meta.last;

endmodule

// ----- rtl/hds_cell.sv -----
// One cell of a line delay chain: holds one grid value.
module hds_cell
    import hds_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_shift,
    input  logic                         i_entry,
    input  logic signed [VALUE_BITS-1:0] i_din,
    input  logic signed [VALUE_BITS-1:0] i_next,
    output logic signed [VALUE_BITS-1:0] o_q
);

    logic signed [VALUE_BITS-1:0] r_q;

    // Entry cell takes the new value, the others take their upstream neighbor
    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_q <= i_entry ? i_din : i_next;
        end
    end

    assign o_q = r_q;

endmodule

// ----- rtl/hds_line.sv -----
// Line delay chain of cells; its length follows the active column count.
module hds_line
    import hds_pkg::*;
#(
    parameter int MAX_COLS   = MAX_COLS_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF,
    localparam int CW        = $clog2(MAX_COLS)
) (
    input  logic                         i_clk,
    input  logic                         i_shift,
    input  logic [CW-1:0]                i_last_idx,   // active columns minus one
    input  logic signed [VALUE_BITS-1:0] i_din,
    output logic signed [VALUE_BITS-1:0] o_tap0,       // value from cols items back
    output logic signed [VALUE_BITS-1:0] o_tap1        // value from cols-1 items back
);

    logic signed [VALUE_BITS-1:0] w_q [MAX_COLS];

    // Data moves toward cell 0; new values enter at cell cols-1
    for (genvar k = 0; k < MAX_COLS; k++) begin : g_cell
        logic signed [VALUE_BITS-1:0] w_next;
        if (k == MAX_COLS - 1) begin : g_end
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = w_q[k+1];
        end
        hds_cell #(
            .VALUE_BITS(VALUE_BITS)
        ) u_cell (
            .i_clk  (i_clk),
            .i_shift(i_shift),
            .i_entry(i_last_idx == CW'(k)),
            .i_din  (i_din),
            .i_next (w_next),
            .o_q    (w_q[k])
        );
    end

    assign o_tap0 = w_q[0];
    assign o_tap1 = w_q[1];

endmodule

// ----- rtl/hds_update.sv -----
// Five-stage update pipeline: second differences, gain products, rounding, saturation.
module hds_update
    import hds_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_adv,
    input  logic                         i_valid,
    input  logic signed [VALUE_BITS-1:0] i_center,
    input  logic signed [VALUE_BITS-1:0] i_up,
    input  logic signed [VALUE_BITS-1:0] i_down,
    input  logic signed [VALUE_BITS-1:0] i_left,
    input  logic signed [VALUE_BITS-1:0] i_right,
    input  t_meta                        i_meta,
    input  logic [GAIN_BITS-1:0]         i_row_gain,
    input  logic [GAIN_BITS-1:0]         i_col_gain,
    output logic                         o_valid,
    output logic [VALUE_BITS-1:0]        o_value,
    output t_meta                        o_meta
);

    localparam int DW = VALUE_BITS + 2;          // second difference
    localparam int GW = GAIN_BITS + 1;           // gain as signed
    localparam int PW = DW + GW;                 // one product
    localparam int SW = PW + 1;                  // sum of products
    localparam int IW = SW - FRAC_BITS;          // rounded increment
    localparam int NW = IW + 1;                  // center plus increment

    localparam logic signed [SW-1:0] HALF   = SW'(ROUND_HALF);
    localparam logic signed [NW-1:0] SAT_HI = (NW'(1) <<< (VALUE_BITS - 1)) - NW'(1);
    localparam logic signed [NW-1:0] SAT_LO = -SAT_HI - NW'(1);

    logic                         r_va, r_vb, r_vc, r_vd, r_ve;
    t_meta                        r_ma, r_mb, r_mc, r_md, r_me;
    logic signed [VALUE_BITS-1:0] r_ca, r_cb, r_cc, r_cd;
    logic signed [VALUE_BITS-1:0] r_up, r_dn, r_lf, r_rt;
    logic signed [DW-1:0]         r_dr, r_dc;
    logic signed [PW-1:0]         r_pr, r_pc;
    logic signed [IW-1:0]         r_inc;
    logic [VALUE_BITS-1:0]        r_out;

    logic signed [GW-1:0] w_gr, w_gc;
    logic signed [SW-1:0] w_sum;
    logic signed [NW-1:0] w_n;
    logic signed [NW-1:0] w_sat;

    assign w_gr = signed'({1'b0, i_row_gain});
    assign w_gc = signed'({1'b0, i_col_gain});

    // Round to nearest, ties up: add half, then floor shift
    assign w_sum = SW'(r_pr) + SW'(r_pc) + HALF;

    // Final add and clamp to the value range
    always_comb begin
        w_n = NW'(r_cd) + NW'(r_inc);
        priority if (w_n > SAT_HI) begin
            w_sat = SAT_HI;
        end else if (w_n < SAT_LO) begin
            w_sat = SAT_LO;
        end else begin
            w_sat = w_n;
        end
    end

    // Valid bits of the stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
            r_ve <= 1'b0;
        end else if (i_adv) begin
            r_va <= i_valid;
            r_vb <= r_va;
            r_vc <= r_vb;
            r_vd <= r_vc;
            r_ve <= r_vd;
        end
    end

    // Datapath stages
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            // operands
            r_ma <= i_meta;
            r_ca <= i_center;
            r_up <= i_up;
            r_dn <= i_down;
            r_lf <= i_left;
            r_rt <= i_right;
            // second differences
            r_mb <= r_ma;
            r_cb <= r_ca;
            r_dr <= DW'(r_up) + DW'(r_dn) - (DW'(r_ca) <<< 1);
            r_dc <= DW'(r_lf) + DW'(r_rt) - (DW'(r_ca) <<< 1);
            // gain products
            r_mc <= r_mb;
            r_cc <= r_cb;
            r_pr <= PW'(r_dr) * PW'(w_gr);
            r_pc <= PW'(r_dc) * PW'(w_gc);
            // rounded increment
            r_md <= r_mc;
            r_cd <= r_cc;
            r_inc <= IW'(w_sum >>> FRAC_BITS);
            // saturated result
            r_me <= r_md;
            r_out <= VALUE_BITS'(w_sat);
        end
    end

    assign o_valid = r_ve;
    assign o_value = r_out;
    assign o_meta  = r_me;

endmodule
